// ----- sv/scan_sector_obstacle_steering_macros.svh -----
// ----------------------------------------------------------------------------
// Scan sector obstacle steering assertion macros
// Concurrent assertion wrappers, empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SCAN_SECTOR_OBSTACLE_STEERING_MACROS_SVH
`define SCAN_SECTOR_OBSTACLE_STEERING_MACROS_SVH

`ifndef SYNTHESIS
`define SSOS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scan_sector_obstacle_steering: assertion failed");
`define SSOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scan_sector_obstacle_steering: assertion failed");
`else
`define SSOS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SSOS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- sv/ssos_pkg.sv -----
// ----------------------------------------------------------------------------
// Scan sector obstacle steering package
// Shared widths, register map, reset values, blocked-sector and LED codes, result type.
// ----------------------------------------------------------------------------
`default_nettype none

package ssos_pkg;

    localparam int RANGE_W = 16;
    localparam int LEN_W   = 13;
    localparam int DIST_W  = 16;
    localparam int SPD_W   = 10;
    localparam int TRN_W   = 11;
    localparam int THR_W   = DIST_W + LEN_W;
    localparam int LIN_W   = 11;
    localparam int ANG_W   = 12;
    localparam int LED_W   = 2;
    localparam int BLK_W   = 3;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_SCAN_LENGTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_DISTANCE  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_CRUISE_SPEED  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TURNING_SPEED = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TURN_RATE     = 3'd4;

    localparam logic [LEN_W-1:0]  RST_SCAN_LENGTH   = 13'd360;
    localparam logic [DIST_W-1:0] RST_MIN_DISTANCE  = 16'd450;
    localparam logic [SPD_W-1:0]  RST_CRUISE_SPEED  = 10'd100;
    localparam logic [SPD_W-1:0]  RST_TURNING_SPEED = 10'd80;
    localparam logic [TRN_W-1:0]  RST_TURN_RATE     = 11'd950;

    localparam logic [LEN_W-1:0]  MIN_LEN = 13'd3;

    // bit0 first third, bit1 middle third, bit2 last third
    localparam logic [BLK_W-1:0] BLK_CLEAR     = 3'b000;
    localparam logic [BLK_W-1:0] BLK_FIRST     = 3'b001;
    localparam logic [BLK_W-1:0] BLK_MIDDLE    = 3'b010;
    localparam logic [BLK_W-1:0] BLK_FIRST_MID = 3'b011;
    localparam logic [BLK_W-1:0] BLK_LAST      = 3'b100;
    localparam logic [BLK_W-1:0] BLK_OUTER     = 3'b101;
    localparam logic [BLK_W-1:0] BLK_MID_LAST  = 3'b110;
    localparam logic [BLK_W-1:0] BLK_ALL       = 3'b111;

    localparam logic [LED_W-1:0] LED_OFF   = 2'd0;
    localparam logic [LED_W-1:0] LED_RIGHT = 2'd3;
    localparam logic [LED_W-1:0] LED_LEFT  = 2'd1;

    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_LEFT,
        DIR_RIGHT
    } dir_t;

    typedef struct packed {
        logic signed [LIN_W-1:0] linear_speed;
        logic signed [ANG_W-1:0] angular_rate;
        logic [LED_W-1:0]        led_one;
        logic [LED_W-1:0]        led_two;
        logic [BLK_W-1:0]        blocked_sectors;
    } decision_t;

endpackage

`default_nettype wire

// ----- sv/scan_sector_obstacle_steering.sv -----
// ----------------------------------------------------------------------------
// Scan sector obstacle steering
// Sums range samples per scan third and issues a steering command per scan.
// ----------------------------------------------------------------------------
// Takes one range sample per clock, in scan index order, and gives one command
// after the last sample of each scan. On the transfer of the last sample, stage A
// registers it with its third selection and the sample count; stage B then
// updates and captures the per-third sums, and the output register then takes
// the threshold compare and the decision table, held while m_ready is low.
// s_ready drops only while a finished command waits in the output register with
// m_ready low and the next command has reached the compare stage; otherwise
// samples keep flowing at one per clock.
// Registers are written over the APB port at byte address 4*index.
`default_nettype none

`include "scan_sector_obstacle_steering_macros.svh"

module scan_sector_obstacle_steering #(
    parameter int MAX_SCAN = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ssos_pkg::PADDR_W-1:0]        paddr,
    input  logic [ssos_pkg::DATA_W-1:0]         pwdata,
    output logic [ssos_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ssos_pkg::RANGE_W-1:0]        s_range_mm,
    input  logic                                s_range_valid,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ssos_pkg::LIN_W-1:0]   m_linear_speed,
    output logic signed [ssos_pkg::ANG_W-1:0]   m_angular_rate,
    output logic [ssos_pkg::LED_W-1:0]          m_led_one,
    output logic [ssos_pkg::LED_W-1:0]          m_led_two,
    output logic [ssos_pkg::BLK_W-1:0]          m_blocked_sectors
);

    import ssos_pkg::*;

    localparam int CNT_W = (MAX_SCAN > 2) ? $clog2(MAX_SCAN) : 2;
    localparam int SUM_W = RANGE_W + CNT_W;
    localparam int CW    = (CNT_W + 2 > LEN_W + 1) ? CNT_W + 2 : LEN_W + 1;
    localparam int MW    = (LEN_W > 17) ? LEN_W : 17;

    // configuration
    logic [LEN_W-1:0]  scan_length_reg;
    logic [DIST_W-1:0] min_distance_reg;
    logic [SPD_W-1:0]  cruise_speed_reg;
    logic [SPD_W-1:0]  turning_speed_reg;
    logic [TRN_W-1:0]  turn_rate_reg;
    logic [THR_W-1:0]  thr_reg;
    logic              cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    // sample count and sector selection
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [LEN_W-1:0]  eff_len;
    logic [CW-1:0]     len_c;
    logic [CW-1:0]     len2_c;
    logic [CW-1:0]     n3;
    logic              scan_end;
    logic [2:0]        sel;
    logic              out_free;
    logic              advance;
    logic              s_accept;

    // stage A
    logic              a_vld_reg;
    logic              a_last_reg;
    logic [2:0]        a_sel_reg;
    logic [RANGE_W-1:0] a_range_reg;

    // stage B
    logic              b_vld_reg;
    logic [SUM_W-1:0]  first_sum_reg;
    logic [SUM_W-1:0]  middle_sum_reg;
    logic [SUM_W-1:0]  last_sum_reg;
    logic [SUM_W-1:0]  first_snap_reg;
    logic [SUM_W-1:0]  middle_snap_reg;
    logic [SUM_W-1:0]  last_snap_reg;
    logic [SUM_W-1:0]  first_add;
    logic [SUM_W-1:0]  middle_add;
    logic [SUM_W-1:0]  last_add;
    logic [SUM_W-1:0]  range_ext;

    // output
    logic              m_valid_reg;
    decision_t         decision;
    decision_t         out_reg;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_length_reg   <= RST_SCAN_LENGTH;
            min_distance_reg  <= RST_MIN_DISTANCE;
            cruise_speed_reg  <= RST_CRUISE_SPEED;
            turning_speed_reg <= RST_TURNING_SPEED;
            turn_rate_reg     <= RST_TURN_RATE;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                REG_SCAN_LENGTH:   scan_length_reg   <= pwdata[LEN_W-1:0];
                REG_MIN_DISTANCE:  min_distance_reg  <= pwdata[DIST_W-1:0];
                REG_CRUISE_SPEED:  cruise_speed_reg  <= pwdata[SPD_W-1:0];
                REG_TURNING_SPEED: turning_speed_reg <= pwdata[SPD_W-1:0];
                REG_TURN_RATE:     turn_rate_reg     <= pwdata[TRN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SCAN_LENGTH:   prdata = DATA_W'(scan_length_reg);
            REG_MIN_DISTANCE:  prdata = DATA_W'(min_distance_reg);
            REG_CRUISE_SPEED:  prdata = DATA_W'(cruise_speed_reg);
            REG_TURNING_SPEED: prdata = DATA_W'(turning_speed_reg);
            REG_TURN_RATE:     prdata = DATA_W'(turn_rate_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        if (scan_length_reg < MIN_LEN) begin
            eff_len = MIN_LEN;
        end else if (MW'(scan_length_reg) > MW'(MAX_SCAN)) begin
            eff_len = LEN_W'(MAX_SCAN);
        end else begin
            eff_len = scan_length_reg;
        end
    end

    always_ff @(posedge aclk) begin
        thr_reg <= THR_W'(min_distance_reg) * THR_W'(eff_len);
    end

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = out_free || !b_vld_reg;
    assign s_ready  = advance;
    assign s_accept = s_valid && advance;

    assign len_c    = CW'(eff_len);
    assign len2_c   = len_c << 1;
    assign n3       = (CW'(cnt_reg) << 1) + CW'(cnt_reg);
    assign scan_end = (CW'(cnt_reg) + CW'(1)) >= len_c;
    assign cnt_next = scan_end ? '0 : cnt_reg + CNT_W'(1);

    // membership: first 3n < L, middle floor(L/3) <= n && 3n < 2L, last floor(2L/3) <= n
    assign sel[0] = n3 < len_c;
    assign sel[1] = ((n3 + CW'(3)) > len_c) && (n3 < len2_c);
    assign sel[2] = (n3 + CW'(3)) > len2_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            a_vld_reg <= 1'b0;
        end else if (advance) begin
            a_vld_reg <= s_valid;
            if (s_valid) begin
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_last_reg  <= scan_end;
            a_sel_reg   <= s_range_valid ? sel : 3'b000;
            a_range_reg <= s_range_mm;
        end
    end

    assign range_ext  = SUM_W'(a_range_reg);
    assign first_add  = first_sum_reg  + (a_sel_reg[0] ? range_ext : '0);
    assign middle_add = middle_sum_reg + (a_sel_reg[1] ? range_ext : '0);
    assign last_add   = last_sum_reg   + (a_sel_reg[2] ? range_ext : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg      <= 1'b0;
            first_sum_reg  <= '0;
            middle_sum_reg <= '0;
            last_sum_reg   <= '0;
        end else if (advance) begin
            b_vld_reg <= a_vld_reg && a_last_reg;
            if (a_vld_reg) begin
                if (a_last_reg) begin
                    first_sum_reg  <= '0;
                    middle_sum_reg <= '0;
                    last_sum_reg   <= '0;
                end else begin
                    first_sum_reg  <= first_add;
                    middle_sum_reg <= middle_add;
                    last_sum_reg   <= last_add;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && a_vld_reg && a_last_reg) begin
            first_snap_reg  <= first_add;
            middle_snap_reg <= middle_add;
            last_snap_reg   <= last_add;
        end
    end

    ssos_decide #(
        .SUM_W(SUM_W)
    ) u_decide (
        .first_sum     (first_snap_reg),
        .middle_sum    (middle_snap_reg),
        .last_sum      (last_snap_reg),
        .thr           (thr_reg),
        .cruise_speed  (cruise_speed_reg),
        .turning_speed (turning_speed_reg),
        .turn_rate     (turn_rate_reg),
        .decision      (decision)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && b_vld_reg) begin
            out_reg <= decision;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_linear_speed    = out_reg.linear_speed;
    assign m_angular_rate    = out_reg.angular_rate;
    assign m_led_one         = out_reg.led_one;
    assign m_led_two         = out_reg.led_two;
    assign m_blocked_sectors = out_reg.blocked_sectors;

    `SSOS_ASSERT_NEXT(a_cnt_wrap, aclk, aresetn, s_accept && scan_end, cnt_reg == '0)
    `SSOS_ASSERT_NEXT(a_snap_load, aclk, aresetn, advance && a_vld_reg && a_last_reg, b_vld_reg)
    `SSOS_ASSERT_IMPL(a_led_excl, aclk, aresetn, m_valid, !(m_led_one != '0 && m_led_two != '0))

endmodule

`default_nettype wire

// ----- sv/ssos_decide.sv -----
// ----------------------------------------------------------------------------
// Scan sector obstacle steering decision
// Flags each third against the threshold and maps the flags to a command.
// ----------------------------------------------------------------------------
`default_nettype none

module ssos_decide #(
    parameter int SUM_W = 28
) (
    input  logic [SUM_W-1:0]              first_sum,
    input  logic [SUM_W-1:0]              middle_sum,
    input  logic [SUM_W-1:0]              last_sum,
    input  logic [ssos_pkg::THR_W-1:0]    thr,
    input  logic [ssos_pkg::SPD_W-1:0]    cruise_speed,
    input  logic [ssos_pkg::SPD_W-1:0]    turning_speed,
    input  logic [ssos_pkg::TRN_W-1:0]    turn_rate,
    output ssos_pkg::decision_t           decision
);

    import ssos_pkg::*;

    localparam int CMP_W = (SUM_W + 2 > THR_W) ? SUM_W + 2 : THR_W;

    logic [CMP_W-1:0]        first3;
    logic [CMP_W-1:0]        middle3;
    logic [CMP_W-1:0]        last3;
    logic [CMP_W-1:0]        thr_ext;
    logic [BLK_W-1:0]        blk;
    logic                    l_ge_f;
    logic                    l_ge_m;
    logic                    m_ge_f;
    logic                    m_ge_l;
    logic                    f_ge_l;
    logic signed [LIN_W-1:0] cruise_s;
    logic signed [LIN_W-1:0] turning_s;
    logic signed [ANG_W-1:0] rate_s;
    logic signed [LIN_W-1:0] speed;
    dir_t                    dir;

    assign first3  = (CMP_W'(first_sum) << 1) + CMP_W'(first_sum);
    assign middle3 = (CMP_W'(middle_sum) << 1) + CMP_W'(middle_sum);
    assign last3   = (CMP_W'(last_sum) << 1) + CMP_W'(last_sum);
    assign thr_ext = CMP_W'(thr);

    assign blk = {last3 < thr_ext, middle3 < thr_ext, first3 < thr_ext};

    assign l_ge_f = last_sum >= first_sum;
    assign l_ge_m = last_sum >= middle_sum;
    assign m_ge_f = middle_sum >= first_sum;
    assign m_ge_l = middle_sum >= last_sum;
    assign f_ge_l = first_sum >= last_sum;

    assign cruise_s  = $signed({1'b0, cruise_speed});
    assign turning_s = $signed({1'b0, turning_speed});
    assign rate_s    = $signed({1'b0, turn_rate});

    always_comb begin
        speed = turning_s;
        dir   = DIR_NONE;
        case (blk) inside
            BLK_CLEAR, BLK_OUTER: begin
                speed = cruise_s;
            end
            BLK_FIRST: begin
                dir = DIR_LEFT;
            end
            BLK_LAST, BLK_MID_LAST: begin
                dir = DIR_RIGHT;
            end
            BLK_FIRST_MID: begin
                speed = '0;
                dir   = DIR_LEFT;
            end
            BLK_MIDDLE: begin
                dir = f_ge_l ? DIR_RIGHT : DIR_LEFT;
            end
            BLK_ALL: begin
                if (l_ge_f && l_ge_m) begin
                    dir = DIR_LEFT;
                end else if (m_ge_f && m_ge_l) begin
                    speed = -cruise_s;
                end else begin
                    dir = DIR_RIGHT;
                end
            end
            default: begin
                speed = cruise_s;
            end
        endcase
    end

    always_comb begin
        decision.linear_speed    = speed;
        decision.blocked_sectors = blk;
        decision.angular_rate    = '0;
        decision.led_one         = LED_OFF;
        decision.led_two         = LED_OFF;
        unique case (dir)
            DIR_LEFT: begin
                decision.angular_rate = rate_s;
                decision.led_two      = LED_LEFT;
            end
            DIR_RIGHT: begin
                decision.angular_rate = -rate_s;
                decision.led_one      = LED_RIGHT;
            end
            default: begin
                decision.angular_rate = '0;
            end
        endcase
    end

endmodule

`default_nettype wire
